@@ hw/rtl/ius_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ius_pkg;

    localparam int PatternLength = 4;
    localparam int TimerBits     = 16;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       alert_level;
        logic [1:0] lock_state;
        logic       last;
    } out_item_t;

    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_UNLOCK = 2'd2;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_ALERT = 2'd1;
    localparam logic [1:0] KIND_LOCK  = 2'd2;

    localparam logic [1:0] LOCK_LOCKED    = 2'd0;
    localparam logic [1:0] LOCK_UNLOCKING = 2'd1;
    localparam logic [1:0] LOCK_UNLOCKED  = 2'd2;
    localparam logic [1:0] LOCK_JAMMED    = 2'd3;

    localparam logic [2:0] REG_CALL_PAT    = 3'd0;
    localparam logic [2:0] REG_CONFIRM_PAT = 3'd1;
    localparam logic [2:0] REG_COMMANDS    = 3'd2;
    localparam logic [2:0] REG_CLEAR_BUS   = 3'd3;
    localparam logic [2:0] REG_ALERT       = 3'd4;
    localparam logic [2:0] REG_TIMEOUT     = 3'd5;
    localparam logic [2:0] REG_DELAY       = 3'd6;

    // Result slot: either a 4-byte frame burst or a single event
    typedef enum logic [2:0] {
        EV_NONE, EV_ALERT_UP, EV_ALERT_DOWN, EV_LOCK, EV_FRAME
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   ev;
        logic [1:0] lock;
        logic [31:0] frame;
    } ev_t;

    localparam int NumEv = 6;

    typedef struct packed {
        logic [31:0] call_pat;
        logic [31:0] confirm_pat;
        logic [15:0] commands;
        logic [31:0] bus_reset_word;
        logic [15:0] alert_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] delay_ticks;
    } cfg_t;

    function automatic logic [TimerBits-1:0] cap_ticks(input logic [15:0] t);
        if (TimerBits >= 16)
            return TimerBits'(t);
        else if ((t >> TimerBits) != 16'd0)
            return '1;
        else
            return t[TimerBits-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ius_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ius_core
    import ius_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire in_item_t      item,
    input  wire cfg_t          cfg,
    output ev_t [NumEv-1:0]    evs
);

    localparam int NT = 6;
    localparam int TA = 0, TCS = 1, TCW = 2, TUS = 3, TUW = 4, TCL = 5;

    typedef enum logic [1:0] {
        PH_IDLE, PH_WAIT_CALL, PH_WAIT_UNLOCK
    } phase_t;

    logic [2:0] call_pos_reg, call_pos_next, conf_pos_reg, conf_pos_next;
    phase_t phase_reg, phase_next;
    logic [NT-1:0] act_reg, act_next;
    logic [NT-1:0][TimerBits-1:0] cnt_reg, cnt_next;

    function automatic logic [7:0] fbyte(input logic [31:0] w, input logic [2:0] k);
        return w[8*(3-k[1:0]) +: 8];
    endfunction

    function automatic logic [2:0] mstep(input logic [2:0] p0, input logic [31:0] w,
                                         input logic [7:0] b, output logic hit);
        logic [2:0] p;
        p = (p0 >= 3'(PatternLength)) ? 3'd0 : p0;
        hit = 1'b0;
        if (b == fbyte(w, p)) begin
            if (p == 3'(PatternLength - 1)) begin
                hit = 1'b1;
                return 3'd0;
            end
            return p + 3'd1;
        end
        return (b == fbyte(w, 3'd0)) ? 3'd1 : 3'd0;
    endfunction

    always_comb
    begin
        logic call_hit, conf_hit;
        logic [NT-1:0] exp_v;
        logic [TimerBits-1:0] dly, tmo;
        logic [31:0] cmd_call, cmd_unl;
        call_pos_next = call_pos_reg;
        conf_pos_next = conf_pos_reg;
        phase_next = phase_reg;
        act_next = act_reg;
        cnt_next = cnt_reg;
        evs = '0;
        exp_v = '0;
        call_hit = 1'b0;
        conf_hit = 1'b0;
        dly = cap_ticks(cfg.delay_ticks);
        tmo = cap_ticks(cfg.timeout_ticks);
        cmd_call = {cfg.confirm_pat[31:8], cfg.commands[15:8]};
        cmd_unl  = {cfg.confirm_pat[31:8], cfg.commands[7:0]};
        case (item.func)
            FUNC_BYTE:
            begin
                call_pos_next = mstep(call_pos_reg, cfg.call_pat, item.rx_byte, call_hit);
                conf_pos_next = mstep(conf_pos_reg, cfg.confirm_pat, item.rx_byte, conf_hit);
                if (call_hit)
                begin
                    evs[0].ev = EV_ALERT_UP;
                    act_next[TA] = 1'b1;
                    cnt_next[TA] = cap_ticks(cfg.alert_ticks);
                end
                if (conf_hit && phase_reg == PH_WAIT_CALL)
                begin
                    act_next[TCW] = 1'b0;
                    cnt_next[TCW] = '0;
                    phase_next = PH_WAIT_UNLOCK;
                    act_next[TUS] = 1'b1;
                    cnt_next[TUS] = dly;
                end
                else if (conf_hit && phase_reg == PH_WAIT_UNLOCK)
                begin
                    act_next[TUW] = 1'b0;
                    cnt_next[TUW] = '0;
                    phase_next = PH_IDLE;
                    act_next[TCL] = 1'b1;
                    cnt_next[TCL] = dly;
                    evs[1].ev = EV_LOCK;
                    evs[1].lock = LOCK_UNLOCKED;
                end
            end
            FUNC_TICK:
            begin
                for (int i = 0; i < NT; i++)
                begin
                    if (act_reg[i])
                    begin
                        if (cnt_reg[i] <= TimerBits'(1))
                        begin
                            act_next[i] = 1'b0;
                            cnt_next[i] = '0;
                            exp_v[i] = 1'b1;
                        end
                        else
                            cnt_next[i] = cnt_reg[i] - TimerBits'(1);
                    end
                end
                if (exp_v[TA])
                    evs[0].ev = EV_ALERT_DOWN;
                if (exp_v[TCS])
                begin
                    evs[1].ev = EV_FRAME;
                    evs[1].frame = cmd_call;
                    act_next[TCW] = 1'b1;
                    cnt_next[TCW] = tmo;
                    exp_v[TCW] = 1'b0;
                end
                if (exp_v[TCW] && phase_next == PH_WAIT_CALL)
                begin
                    phase_next = PH_IDLE;
                    act_next[TCL] = 1'b1;
                    cnt_next[TCL] = dly;
                    exp_v[TCL] = 1'b0;
                    evs[2].ev = EV_LOCK;
                    evs[2].lock = LOCK_JAMMED;
                end
                if (exp_v[TUS])
                begin
                    evs[3].ev = EV_FRAME;
                    evs[3].frame = cmd_unl;
                    act_next[TUW] = 1'b1;
                    cnt_next[TUW] = tmo;
                    exp_v[TUW] = 1'b0;
                end
                if (exp_v[TUW] && phase_next == PH_WAIT_UNLOCK)
                begin
                    phase_next = PH_IDLE;
                    act_next[TCL] = 1'b1;
                    cnt_next[TCL] = dly;
                    exp_v[TCL] = 1'b0;
                    evs[4].ev = EV_LOCK;
                    evs[4].lock = LOCK_JAMMED;
                end
                if (exp_v[TCL])
                begin
                    evs[5].ev = EV_FRAME;
                    evs[5].frame = cfg.bus_reset_word;
                end
            end
            FUNC_UNLOCK:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    evs[0].ev = EV_LOCK;
                    evs[0].lock = LOCK_UNLOCKING;
                    evs[1].ev = EV_FRAME;
                    evs[1].frame = cfg.bus_reset_word;
                    phase_next = PH_WAIT_CALL;
                    act_next[TCS] = 1'b1;
                    cnt_next[TCS] = dly;
                end
            end
            default:
            begin
                evs = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            call_pos_reg <= '0;
            conf_pos_reg <= '0;
            phase_reg <= PH_IDLE;
            act_reg <= '0;
            cnt_reg <= '0;
        end
        else if (go)
        begin
            call_pos_reg <= call_pos_next;
            conf_pos_reg <= conf_pos_next;
            phase_reg <= phase_next;
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE || phase_reg == PH_WAIT_CALL || phase_reg == PH_WAIT_UNLOCK)
        else $error("sequence phase out of range");
    a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
        call_pos_reg < 3'd4 && conf_pos_reg < 3'd4) else $error("matcher position bad");
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        go && item.func == FUNC_UNLOCK && phase_reg == PH_IDLE |=> phase_reg == PH_WAIT_CALL)
        else $error("unlock request did not start sequence");

endmodule
`default_nettype wire

@@ hw/rtl/ius_serializer.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ius_serializer
    import ius_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire ev_t [NumEv-1:0] evs,
    output logic                 busy,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output out_item_t            out_item
);

    ev_t [NumEv-1:0] q_reg;
    logic [NumEv-1:0] pend_reg;
    logic [1:0] byte_reg;
    logic [2:0] sel;
    logic any;
    logic more;
    ev_t cur;

    always_comb
    begin
        sel = '0;
        any = 1'b0;
        for (int i = NumEv - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = 3'(i);
                any = 1'b1;
            end
        end
        cur = q_reg[sel];
        more = 1'b0;
        for (int i = 0; i < NumEv; i++)
            if (pend_reg[i] && 3'(i) > sel)
                more = 1'b1;
    end

    logic seg_end;
    assign seg_end = (cur.ev != EV_FRAME) || (byte_reg == 2'd3);

    always_comb
    begin
        out_item = '0;
        case (cur.ev)
            EV_ALERT_UP:
            begin
                out_item.kind = KIND_ALERT;
                out_item.alert_level = 1'b1;
            end
            EV_ALERT_DOWN:
                out_item.kind = KIND_ALERT;
            EV_LOCK:
            begin
                out_item.kind = KIND_LOCK;
                out_item.lock_state = cur.lock;
            end
            EV_FRAME:
            begin
                out_item.kind = KIND_TX;
                out_item.tx_byte = cur.frame[8*(3-byte_reg) +: 8];
            end
            default:
                out_item.kind = KIND_TX;
        endcase
        out_item.last = seg_end && !more;
    end

    assign out_valid = any;
    assign busy = any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            byte_reg <= '0;
        end
        else if (load)
        begin
            for (int i = 0; i < NumEv; i++)
                pend_reg[i] <= (evs[i].ev != EV_NONE);
            byte_reg <= '0;
        end
        else if (any && out_ready)
        begin
            if (seg_end)
            begin
                pend_reg[sel] <= 1'b0;
                byte_reg <= '0;
            end
            else
                byte_reg <= byte_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            q_reg <= evs;
    end

    // A load may only overlap the transfer of the final pending result
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !any || (out_ready && out_item.last)) else $error("load while results pending");
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_item.last && !load |=> !out_valid)
        else $error("results after last");
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur.ev != EV_FRAME && any |-> byte_reg == 2'd0) else $error("byte index stray");

endmodule
`default_nettype wire

@@ hw/rtl/ius_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ius_cfg_regs
    import ius_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{32'd0, 32'd0, 16'd0, 32'd0, 16'd1000, 16'd5000, 16'd100};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CALL_PAT:    cfg_reg.call_pat <= cfg_data;
                REG_CONFIRM_PAT: cfg_reg.confirm_pat <= cfg_data;
                REG_COMMANDS:    cfg_reg.commands <= cfg_data[15:0];
                REG_CLEAR_BUS:   cfg_reg.bus_reset_word <= cfg_data;
                REG_ALERT:       cfg_reg.alert_ticks <= cfg_data[15:0];
                REG_TIMEOUT:     cfg_reg.timeout_ticks <= cfg_data[15:0];
                REG_DELAY:       cfg_reg.delay_ticks <= cfg_data[15:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/intercom_unlock_sequencer.sv @@
// Intercom unlock sequencer.
// Input channel (in_valid/in_ready/in_item) carries received bus bytes,
// millisecond ticks and unlock requests. Output channel (out_valid/out_ready/
// out_item) returns transmit bytes, alert level changes and lock state changes;
// the final result of each item has last set, and items with no result emit none.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data, always ready.
// An accepted item is processed in the transfer cycle; its results appear from
// the next cycle, one per cycle while out_ready is high, up to thirteen results.
// A new item is accepted in the same cycle as the last result transfers; an
// item with no results does not hold in_ready low.
// A stalled receiver holds out_item steady and in_ready low.
// Reset clears matchers, sequence phase, all timers and pending results, and
// loads the register defaults (alert 1000, timeout 5000, delay 100 ticks).
`timescale 1ns / 1ps
`default_nettype none
module intercom_unlock_sequencer
    import ius_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t cfg;
    ev_t [NumEv-1:0] evs;
    logic busy, go, last_xfer;

    assign cfg_ready = 1'b1;
    assign last_xfer = out_valid && out_ready && out_item.last;
    assign in_ready = !busy || last_xfer;
    assign go = in_valid && in_ready;

    ius_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
    );

    ius_core u_core (
        .clk(clk), .rst_n(rst_n), .go(go), .item(in_item), .cfg(cfg), .evs(evs)
    );

    ius_serializer u_ser (
        .clk(clk), .rst_n(rst_n), .load(go), .evs(evs), .busy(busy),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

endmodule
`default_nettype wire
